// ----- design/assert_macros.svh -----
// Assertion macros shared by the core's modules.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define CPU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define CPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define CPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cpu16_pkg.sv -----
`default_nettype none

package cpu16_pkg;

    // Item kinds on the input channel
    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

    // Instruction opcodes (bits 15:11)
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_ADDI = 5'd2;
    localparam logic [4:0] OP_SUBI = 5'd3;
    localparam logic [4:0] OP_MOV  = 5'd4;
    localparam logic [4:0] OP_MOVI = 5'd5;
    localparam logic [4:0] OP_SW   = 5'd6;
    localparam logic [4:0] OP_LW   = 5'd7;
    localparam logic [4:0] OP_CMP  = 5'd8;
    localparam logic [4:0] OP_JMP  = 5'd9;
    localparam logic [4:0] OP_SET  = 5'd10;
    localparam logic [4:0] OP_HALT = 5'd11;

    // Condition codes carried in the immediate of JMP and SET
    localparam logic [7:0] COND_AL = 8'd0;
    localparam logic [7:0] COND_EQ = 8'd1;
    localparam logic [7:0] COND_NE = 8'd2;
    localparam logic [7:0] COND_NS = 8'd3;
    localparam logic [7:0] COND_GT = 8'd4;
    localparam logic [7:0] COND_LT = 8'd5;

    // Reset content of register seven
    localparam logic [15:0] R7_RESET = 16'h00FF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic fetch;
        logic decode;
        logic wrap_start;
        logic load_commit;
        logic idle_commit;
        logic exec_commit;
        logic lw_issue;
        logic lw_commit;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic stopped;
        logic need_wrap;
        logic is_lw;
        logic wrap_done;
    } status_t;

endpackage

`default_nettype wire

// ----- design/cpu16_wrap.sv -----
`default_nettype none

// Reduce a 16-bit address modulo the memory depth.
// Power-of-two depth: a mask, always ready.
// Other depths: multiply by the reciprocal of the depth for a quotient estimate,
// form the remainder, then subtract the depth once if it is still too large.
// The stages run in turn: quotient, remainder, then correction, after which done is raised.
module cpu16_wrap
    import cpu16_pkg::*;
#(
    parameter int MEM_DEPTH = 256,
    localparam int AW = $clog2(MEM_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [15:0]   value,
    output logic          done,
    output logic [AW-1:0] result
);

    localparam bit IS_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

    if (IS_POW2) begin : g_mask
        // Keep the low address bits
        assign done   = 1'b1;
        assign result = value[AW-1:0];
    end else begin : g_recip
        // floor(2^32 / depth): the estimate is the true quotient or one below it
        localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(MEM_DEPTH));
        localparam logic [15:0] DEPTH16 = 16'(MEM_DEPTH);

        localparam logic [1:0] PH_IDLE = 2'd0;
        localparam logic [1:0] PH_QUOT = 2'd1;
        localparam logic [1:0] PH_REM  = 2'd2;
        localparam logic [1:0] PH_FIX  = 2'd3;

        logic [15:0] val_reg, val_next;
        logic [15:0] quot_reg, quot_next;
        logic [15:0] rem_reg, rem_next;
        logic [1:0]  phase_reg, phase_next;
        logic        done_reg, done_next;
        logic [47:0] prod_q;
        logic [31:0] prod_d;

        assign prod_q = 48'(val_reg) * 48'(RECIP);
        assign prod_d = 32'(quot_reg) * 32'(DEPTH16);

        // Estimate the quotient, take the remainder, correct it once
        always_comb begin
            val_next   = val_reg;
            quot_next  = quot_reg;
            rem_next   = rem_reg;
            phase_next = phase_reg;
            done_next  = done_reg;
            if (start) begin
                val_next   = value;
                phase_next = PH_QUOT;
                done_next  = 1'b0;
            end else begin
                case (phase_reg)
                    PH_QUOT: begin
                        quot_next  = prod_q[47:32];
                        phase_next = PH_REM;
                    end
                    PH_REM: begin
                        rem_next   = val_reg - prod_d[15:0];
                        phase_next = PH_FIX;
                    end
                    PH_FIX: begin
                        if (rem_reg >= DEPTH16) begin
                            rem_next = rem_reg - DEPTH16;
                        end
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                phase_reg <= PH_IDLE;
                done_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                done_reg  <= done_next;
            end
        end

        always_ff @(posedge aclk) begin
            val_reg  <= val_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end

        assign done   = done_reg & ~start;
        assign result = rem_reg[AW-1:0];
    end

endmodule

`default_nettype wire

// ----- design/cpu16_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module cpu16_datapath
    import cpu16_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_opcode,
    input  logic [7:0]  s_load_address,
    input  logic [15:0] s_load_word,
    input  cmd_t        cmd,
    output status_t     st,
    output logic [7:0]  m_pc,
    output logic        m_halted,
    output logic [2:0]  m_status_flags,
    output logic        m_reg_written,
    output logic [2:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic        m_mem_written,
    output logic [7:0]  m_mem_address,
    output logic [15:0] m_mem_value
);

    localparam int AW = $clog2(MEM_DEPTH);

    // Captured input word
    logic        in_op_reg;
    logic [7:0]  load_addr_reg;
    logic [15:0] load_word_reg;

    // Word memory and its ports
    logic [15:0]   mem_reg [MEM_DEPTH];
    logic [15:0]   mem_rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] clr_reg, clr_next;

    // Architectural state
    logic [7:0] pc_reg, pc_next;
    logic [2:0] flags_reg, flags_next;
    logic       stopped_reg, stopped_next;

    // Register file with reset-valid bits
    logic [15:0] rf_reg [8];
    logic [7:0]  rf_valid_reg, rf_valid_next;
    logic        rf_we;
    logic [15:0] rf_wdata;
    logic [15:0] rd_rdata, ra_rdata;

    // Decoded instruction and operands
    logic [15:0] instr_reg, rd_val_reg, ra_val_reg;
    logic [4:0]  op;
    logic [2:0]  rd_idx;
    logic [7:0]  imm8;
    logic [4:0]  simm5;
    logic [15:0] sx8, sx5, cmp_t;
    logic [2:0]  cmp_flags;
    logic        c_eq, c_lt, c_gt, jmp_taken, set_bit;
    logic        exe_rw;
    logic [15:0] exe_val;
    logic [16:0] pc_inc;
    logic [7:0]  pc_seq;

    // Address wrap unit
    logic [15:0]   wrap_value;
    logic          wrap_done;
    logic [AW-1:0] wrap_result;

    // Result word
    logic [7:0]  out_pc_reg;
    logic        out_halted_reg;
    logic [2:0]  out_flags_reg;
    logic        out_rw_reg;
    logic [2:0]  out_ri_reg;
    logic [15:0] out_rv_reg;
    logic        out_mw_reg;
    logic [7:0]  out_ma_reg;
    logic [15:0] out_mv_reg;

    cpu16_wrap #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_wrap (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.wrap_start),
        .value  (wrap_value),
        .done   (wrap_done),
        .result (wrap_result)
    );

    // Field decode
    assign op     = instr_reg[15:11];
    assign rd_idx = instr_reg[10:8];
    assign imm8   = instr_reg[7:0];
    assign simm5  = instr_reg[4:0];
    assign sx8    = {{8{imm8[7]}}, imm8};
    assign sx5    = {{11{simm5[4]}}, simm5};

    // Compare flags and conditions
    assign cmp_t     = rd_val_reg - ra_val_reg;
    assign cmp_flags = {cmp_t[15] ^ cmp_t[14], cmp_t[15], cmp_t == 16'd0};
    assign c_eq      = flags_reg[0];
    assign c_lt      = flags_reg[1] ^ flags_reg[2];
    assign c_gt      = !c_eq && !c_lt;

    always_comb begin
        case (imm8)
            COND_AL: jmp_taken = 1'b1;
            COND_EQ: jmp_taken = c_eq;
            COND_NE: jmp_taken = !c_eq;
            COND_NS: jmp_taken = !flags_reg[1];
            COND_GT: jmp_taken = c_gt;
            COND_LT: jmp_taken = c_lt;
            default: jmp_taken = 1'b0;
        endcase
    end

    always_comb begin
        case (imm8)
            COND_EQ: set_bit = c_eq;
            COND_GT: set_bit = c_gt;
            COND_LT: set_bit = c_lt;
            default: set_bit = 1'b0;
        endcase
    end

    // Register results of the ALU-type instructions
    always_comb begin
        exe_rw  = 1'b0;
        exe_val = 16'd0;
        case (op)
            OP_ADD: begin
                exe_rw  = 1'b1;
                exe_val = rd_val_reg + ra_val_reg;
            end
            OP_ADDI: begin
                exe_rw  = 1'b1;
                exe_val = rd_val_reg + sx8;
            end
            OP_SUBI: begin
                exe_rw  = 1'b1;
                exe_val = rd_val_reg - sx8;
            end
            OP_MOV: begin
                exe_rw  = 1'b1;
                exe_val = ra_val_reg;
            end
            OP_MOVI: begin
                exe_rw  = 1'b1;
                exe_val = {8'b0, imm8};
            end
            OP_SET: begin
                exe_rw  = 1'b1;
                exe_val = {15'b0, set_bit};
            end
            default: begin
                exe_rw  = 1'b0;
                exe_val = 16'd0;
            end
        endcase
    end

    // Select the address to wrap: load address, branch target or data address
    always_comb begin
        if (in_op_reg == ITEM_LOAD) begin
            wrap_value = {8'b0, load_addr_reg};
        end else if (op == OP_JMP) begin
            wrap_value = rd_val_reg;
        end else begin
            wrap_value = ra_val_reg + sx5;
        end
    end

    // Sequential pc, wrapped at the memory depth
    assign pc_inc = 17'(pc_reg) + 17'd1;
    assign pc_seq = (pc_inc == 17'(MEM_DEPTH)) ? 8'd0 : pc_inc[7:0];

    // Next architectural state
    always_comb begin
        pc_next      = pc_reg;
        flags_next   = flags_reg;
        stopped_next = stopped_reg;
        if (cmd.exec_commit) begin
            if (op == OP_HALT) begin
                stopped_next = 1'b1;
            end else begin
                if (op == OP_CMP) begin
                    flags_next = cmp_flags;
                end
                if (op == OP_JMP && jmp_taken) begin
                    pc_next = 8'(wrap_result);
                end else begin
                    pc_next = pc_seq;
                end
            end
        end else if (cmd.lw_commit) begin
            pc_next = pc_seq;
        end
    end

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wrap_result;
        mem_wdata = rd_val_reg;
        if (cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 16'd0;
        end else if (cmd.load_commit) begin
            mem_we    = 1'b1;
            mem_wdata = load_word_reg;
        end else if (cmd.exec_commit && op == OP_SW) begin
            mem_we    = 1'b1;
        end
    end

    assign mem_re    = cmd.fetch || cmd.lw_issue;
    assign mem_raddr = cmd.fetch ? AW'(pc_reg) : wrap_result;
    assign clr_next  = cmd.clear ? clr_reg + AW'(1) : clr_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem_reg[mem_raddr];
        end
    end

    // Register file: one write port, two registered read ports
    assign rf_we    = (cmd.exec_commit && exe_rw) || cmd.lw_commit;
    assign rf_wdata = cmd.lw_commit ? mem_rdata_reg : exe_val;

    always_comb begin
        rf_valid_next = rf_valid_reg;
        if (rf_we) begin
            rf_valid_next[rd_idx] = 1'b1;
        end
    end

    always_comb begin
        if (rf_valid_reg[mem_rdata_reg[10:8]]) begin
            rd_rdata = rf_reg[mem_rdata_reg[10:8]];
        end else begin
            rd_rdata = (mem_rdata_reg[10:8] == 3'd7) ? R7_RESET : 16'd0;
        end
        if (rf_valid_reg[mem_rdata_reg[7:5]]) begin
            ra_rdata = rf_reg[mem_rdata_reg[7:5]];
        end else begin
            ra_rdata = (mem_rdata_reg[7:5] == 3'd7) ? R7_RESET : 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_reg[rd_idx] <= rf_wdata;
        end
        if (cmd.decode) begin
            instr_reg  <= mem_rdata_reg;
            rd_val_reg <= rd_rdata;
            ra_val_reg <= ra_rdata;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= 8'd0;
            flags_reg    <= 3'd0;
            stopped_reg  <= 1'b0;
            rf_valid_reg <= 8'd0;
            clr_reg      <= '0;
        end else begin
            pc_reg       <= pc_next;
            flags_reg    <= flags_next;
            stopped_reg  <= stopped_next;
            rf_valid_reg <= rf_valid_next;
            clr_reg      <= clr_next;
        end
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_op_reg     <= s_opcode;
            load_addr_reg <= s_load_address;
            load_word_reg <= s_load_word;
        end
    end

    // Load the result word on any commit
    always_ff @(posedge aclk) begin
        if (cmd.load_commit || cmd.idle_commit || cmd.exec_commit || cmd.lw_commit) begin
            out_pc_reg     <= pc_next;
            out_halted_reg <= stopped_next;
            out_flags_reg  <= flags_next;
            out_rw_reg     <= 1'b0;
            out_ri_reg     <= 3'd0;
            out_rv_reg     <= 16'd0;
            out_mw_reg     <= 1'b0;
            out_ma_reg     <= 8'd0;
            out_mv_reg     <= 16'd0;
            if (cmd.lw_commit || (cmd.exec_commit && exe_rw)) begin
                out_rw_reg <= 1'b1;
                out_ri_reg <= rd_idx;
                out_rv_reg <= rf_wdata;
            end
            if (cmd.exec_commit && op == OP_SW) begin
                out_mw_reg <= 1'b1;
                out_ma_reg <= 8'(wrap_result);
                out_mv_reg <= rd_val_reg;
            end
        end
    end

    assign m_pc           = out_pc_reg;
    assign m_halted       = out_halted_reg;
    assign m_status_flags = out_flags_reg;
    assign m_reg_written  = out_rw_reg;
    assign m_reg_index    = out_ri_reg;
    assign m_reg_value    = out_rv_reg;
    assign m_mem_written  = out_mw_reg;
    assign m_mem_address  = out_ma_reg;
    assign m_mem_value    = out_mv_reg;

    // Status toward the controller
    assign st.clear_last = (clr_reg == AW'(MEM_DEPTH - 1));
    assign st.stopped    = stopped_reg;
    assign st.need_wrap  = (op inside {OP_SW, OP_LW}) || (op == OP_JMP && jmp_taken);
    assign st.is_lw      = (op == OP_LW);
    assign st.wrap_done  = wrap_done;

    `CPU_ASSERT_NXT(a_stop_sticky, stopped_reg, stopped_reg, "halt state left without reset")
    `CPU_ASSERT_IMP(a_no_exec_halted, cmd.exec_commit, !stopped_reg, "instruction run after halt")

endmodule

`default_nettype wire

// ----- design/cpu16_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module cpu16_ctrl
    import cpu16_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_opcode,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_EXEC   = 4'd3;
    localparam logic [3:0] S_EXWAIT = 4'd4;
    localparam logic [3:0] S_LWB    = 4'd5;
    localparam logic [3:0] S_LOAD   = 4'd6;
    localparam logic [3:0] S_LDWAIT = 4'd7;
    localparam logic [3:0] S_STOP   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free, commit;
    logic [3:0] commit_vec;

    assign out_free = !m_valid_reg || m_ready;

    // Sequence one word at a time
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (st.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_opcode == ITEM_LOAD) begin
                        state_next = S_LOAD;
                    end else if (st.stopped) begin
                        state_next = S_STOP;
                    end else begin
                        cmd.fetch  = 1'b1;
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (st.need_wrap) begin
                    cmd.wrap_start = 1'b1;
                    if (st.wrap_done && st.is_lw) begin
                        cmd.lw_issue = 1'b1;
                        state_next   = S_LWB;
                    end else if (st.wrap_done && out_free) begin
                        cmd.exec_commit = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        state_next = S_EXWAIT;
                    end
                end else if (out_free) begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EXWAIT: begin
                if (st.wrap_done && st.is_lw) begin
                    cmd.lw_issue = 1'b1;
                    state_next   = S_LWB;
                end else if (st.wrap_done && out_free) begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LWB: begin
                if (out_free) begin
                    cmd.lw_commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_LOAD: begin
                cmd.wrap_start = 1'b1;
                if (st.wrap_done && out_free) begin
                    cmd.load_commit = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    state_next = S_LDWAIT;
                end
            end
            S_LDWAIT: begin
                if (st.wrap_done && out_free) begin
                    cmd.load_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_STOP: begin
                if (out_free) begin
                    cmd.idle_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    assign commit_vec   = {cmd.load_commit, cmd.idle_commit, cmd.exec_commit, cmd.lw_commit};
    assign commit       = |commit_vec;
    assign m_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `CPU_ASSERT(a_commit_onehot, $onehot0(commit_vec), "two commits at once")
    `CPU_ASSERT_NXT(a_commit_shows, commit, m_valid_reg, "committed word not presented")

endmodule

`default_nettype wire

// ----- design/small_16bit_cpu_core.sv -----
// Load word steps: accept, memory write. Plain step: accept with instruction fetch,
// register read, execute. LW adds a data read.
// One word is in flight at a time.
// A depth that is not a power of two replaces the address mask with a sequential wrap.
// Reset is synchronous active low; afterwards the memory is cleared word by word
// with s_ready low, registers zero except register seven at 0xFF.
`default_nettype none

module small_16bit_cpu_core
    import cpu16_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_load_address,
    input  logic [15:0] s_load_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pc,
    output logic        m_halted,
    output logic [2:0]  m_status_flags,
    output logic        m_reg_written,
    output logic [2:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic        m_mem_written,
    output logic [7:0]  m_mem_address,
    output logic [15:0] m_mem_value
);

    cmd_t    cmd;
    status_t st;

    cpu16_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_opcode(s_opcode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    cpu16_datapath #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_opcode      (s_opcode),
        .s_load_address(s_load_address),
        .s_load_word   (s_load_word),
        .cmd           (cmd),
        .st            (st),
        .m_pc          (m_pc),
        .m_halted      (m_halted),
        .m_status_flags(m_status_flags),
        .m_reg_written (m_reg_written),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .m_mem_written (m_mem_written),
        .m_mem_address (m_mem_address),
        .m_mem_value   (m_mem_value)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb
    import cpu16_pkg::*;
();

    localparam int ROW_COUNT        = 30;
    localparam int TAIL_FIRST       = 25;
    localparam int RANDOM_END       = 1545;
    localparam int QUIET_FROM       = 1400;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 20;

    typedef struct packed {
        logic [7:0]  pc;
        logic        halted;
        logic [2:0]  flags;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [7:0]  mem_address;
        logic [15:0] mem_value;
    } cpu_result_t;

    // One directed word; at_pc puts the load address on the current program counter
    typedef struct packed {
        logic        kind;
        logic        at_pc;
        logic [7:0]  addr;
        logic [15:0] word;
        logic        typed;
        logic [7:0]  typed_pc;
    } stim_row_t;

    localparam stim_row_t ROWS [ROW_COUNT] = '{
        // fetch of zeroed memory after reset, extreme load, plain load
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b1, 8'd1},
        '{ITEM_LOAD, 1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'd1},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_MOVI, 3'd0, 8'h80}, 1'b1, 8'd1},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_ADDI, 3'd0, 8'hFF}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'hA5, 16'h5A5A, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_SUBI, 3'd1, 8'h80}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_ADD, 3'd0, 3'd7, 5'd0}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_MOV, 3'd2, 3'd7, 5'd0}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        // store and load with a negative offset
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_SW, 3'd1, 3'd7, 5'h10}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_LW, 3'd3, 3'd7, 5'h10}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_CMP, 3'd1, 3'd7, 5'd0}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_SET, 3'd4, COND_LT}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        // jump to the top word, which holds an unknown opcode, then wrap to zero
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_JMP, 3'd2, COND_AL}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_SET, 3'd5, 8'd7}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        // halt, then steps that must change nothing while loads still land
        '{ITEM_LOAD, 1'b1, 8'h00, {OP_HALT, 11'd0}, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'd0},
        '{ITEM_LOAD, 1'b0, 8'h3C, 16'h1234, 1'b0, 8'd0},
        '{ITEM_STEP, 1'b0, 8'h00, 16'h0000, 1'b0, 8'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [7:0]  s_load_address;
    logic [15:0] s_load_word;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_pc;
    logic        m_halted;
    logic [2:0]  m_status_flags;
    logic        m_reg_written;
    logic [2:0]  m_reg_index;
    logic [15:0] m_reg_value;
    logic        m_mem_written;
    logic [7:0]  m_mem_address;
    logic [15:0] m_mem_value;

    // Shadow state of the core
    logic [15:0] shadow_regs [8];
    logic [15:0] shadow_mem [256];
    logic [7:0]  shadow_pc;
    logic [2:0]  shadow_flags;
    logic        shadow_halted;

    cpu_result_t pending_results [$];
    int          words_sent;
    int          mismatch_count;
    int          quiet_cycles;
    logic        long_hold_done;
    logic        calm;

    small_16bit_cpu_core #(.MEM_DEPTH(256)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_load_address (s_load_address),
        .s_load_word    (s_load_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pc           (m_pc),
        .m_halted       (m_halted),
        .m_status_flags (m_status_flags),
        .m_reg_written  (m_reg_written),
        .m_reg_index    (m_reg_index),
        .m_reg_value    (m_reg_value),
        .m_mem_written  (m_mem_written),
        .m_mem_address  (m_mem_address),
        .m_mem_value    (m_mem_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stretches with no idling on either side, and none at all near the end
    assign calm = ((words_sent % 300) >= 200) || (words_sent >= QUIET_FROM);

    // Evaluate a branch or set condition against the current flags
    function automatic logic cond_holds(input logic [7:0] cond, input logic for_set);
        logic zero;
        logic less;
        zero = shadow_flags[0];
        less = shadow_flags[1] ^ shadow_flags[2];
        case (cond)
            COND_AL: return !for_set;
            COND_EQ: return zero;
            COND_NE: return for_set ? 1'b0 : !zero;
            COND_NS: return for_set ? 1'b0 : !shadow_flags[1];
            COND_GT: return !zero && !less;
            COND_LT: return less;
            default: return 1'b0;
        endcase
    endfunction

    // Apply one word to the shadow state and return the result it should produce
    function automatic cpu_result_t execute_word(input logic kind, input logic [7:0] laddr,
                                                 input logic [15:0] lword);
        cpu_result_t res;
        logic [15:0] insn;
        logic [4:0]  op;
        logic [2:0]  rd;
        logic [2:0]  ra;
        logic [7:0]  imm;
        logic [15:0] d_val;
        logic [15:0] a_val;
        logic [15:0] sum;
        logic [15:0] diff;
        logic [7:0]  daddr;
        logic        taken;
        res = '0;
        if (kind == ITEM_LOAD) begin
            shadow_mem[laddr] = lword;
        end else if (!shadow_halted) begin
            insn  = shadow_mem[shadow_pc];
            op    = insn[15:11];
            rd    = insn[10:8];
            ra    = insn[7:5];
            imm   = insn[7:0];
            d_val = shadow_regs[rd];
            a_val = shadow_regs[ra];
            sum   = a_val + {{11{insn[4]}}, insn[4:0]};
            daddr = sum[7:0];
            taken = 1'b0;
            case (op)
                OP_ADD: begin
                    res.reg_written = 1'b1;
                    res.reg_value = d_val + a_val;
                end
                OP_ADDI: begin
                    res.reg_written = 1'b1;
                    res.reg_value = d_val + {{8{imm[7]}}, imm};
                end
                OP_SUBI: begin
                    res.reg_written = 1'b1;
                    res.reg_value = d_val - {{8{imm[7]}}, imm};
                end
                OP_MOV: begin
                    res.reg_written = 1'b1;
                    res.reg_value = a_val;
                end
                OP_MOVI: begin
                    res.reg_written = 1'b1;
                    res.reg_value = {8'd0, imm};
                end
                OP_SW: begin
                    res.mem_written = 1'b1;
                    res.mem_address = daddr;
                    res.mem_value = d_val;
                    shadow_mem[daddr] = d_val;
                end
                OP_LW: begin
                    res.reg_written = 1'b1;
                    res.reg_value = shadow_mem[daddr];
                end
                OP_CMP: begin
                    diff = d_val - a_val;
                    shadow_flags = {diff[15] ^ diff[14], diff[15], diff == 16'd0};
                end
                OP_JMP: taken = cond_holds(imm, 1'b0);
                OP_SET: begin
                    res.reg_written = 1'b1;
                    res.reg_value = {15'd0, cond_holds(imm, 1'b1)};
                end
                OP_HALT: shadow_halted = 1'b1;
                default: ;
            endcase
            if (res.reg_written) begin
                res.reg_index = rd;
                shadow_regs[rd] = res.reg_value;
            end
            if (op != OP_HALT) begin
                shadow_pc = taken ? shadow_regs[rd][7:0] : shadow_pc + 8'd1;
            end
        end
        res.pc = shadow_pc;
        res.halted = shadow_halted;
        res.flags = shadow_flags;
        return res;
    endfunction

    // Random instruction that never halts; conditions mostly in the defined range
    function automatic logic [15:0] random_instruction();
        logic [4:0]  op;
        logic [15:0] insn;
        if ($urandom_range(0, 9) == 0) begin
            op = 5'($urandom_range(12, 31));
        end else begin
            op = 5'($urandom_range(0, 10));
        end
        insn = {op, 11'($urandom)};
        if ((op == OP_JMP || op == OP_SET) && $urandom_range(0, 4) != 0) begin
            insn[7:0] = 8'($urandom_range(0, 7));
        end
        return insn;
    endfunction

    // Offer one word, hold it until accepted, then record what it should produce
    task automatic send_word(input logic kind, input logic [7:0] addr, input logic [15:0] word,
                             input logic typed, input cpu_result_t typed_res);
        cpu_result_t predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= kind;
        s_load_address <= addr;
        s_load_word    <= word;
        do @(posedge aclk); while (!s_ready);
        predicted = execute_word(kind, addr, word);
        pending_results.push_back(typed ? typed_res : predicted);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_row(input stim_row_t row);
        cpu_result_t typed_res;
        typed_res = '0;
        typed_res.pc = row.typed_pc;
        send_word(row.kind, row.at_pc ? shadow_pc : row.addr, row.word, row.typed, typed_res);
    endtask

    // Step the core; replace a halt word at the program counter first
    task automatic step_cpu();
        if (shadow_mem[shadow_pc][15:11] == OP_HALT) begin
            send_word(ITEM_LOAD, shadow_pc, random_instruction(), 1'b0, '0);
        end
        send_word(ITEM_STEP, 8'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [15:0] expected,
                                 input logic [15:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s expected %h actual %h", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    initial begin : stimulus
        int pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = ITEM_LOAD;
        s_load_address = 8'd0;
        s_load_word    = 16'd0;
        words_sent     = 0;
        mismatch_count = 0;
        foreach (shadow_regs[i]) shadow_regs[i] = 16'd0;
        foreach (shadow_mem[i]) shadow_mem[i] = 16'd0;
        shadow_regs[7] = R7_RESET;
        shadow_pc      = 8'd0;
        shadow_flags   = 3'd0;
        shadow_halted  = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < TAIL_FIRST; i++) send_row(ROWS[i]);

        // Mostly load-then-step with random content, plus stray loads and bare steps
        while (words_sent < RANDOM_END) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_word(ITEM_LOAD, shadow_pc, random_instruction(), 1'b0, '0);
                step_cpu();
            end else if (pick < 75) begin
                step_cpu();
            end else if (pick < 92) begin
                send_word(ITEM_LOAD, 8'($urandom), 16'($urandom), 1'b0, '0);
            end else begin
                send_word(ITEM_LOAD, shadow_pc, 16'($urandom), 1'b0, '0);
            end
        end

        for (int i = TAIL_FIRST; i < ROW_COUNT; i++) send_row(ROWS[i]);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stalls, and one long hold-off so the core backs up
    initial begin : result_sink
        m_ready = 1'b0;
        long_hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && words_sent >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check each result word against the oldest expectation; watch for a hang
    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        cpu_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, pc %h", $time, m_pc);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("pc", want.pc, m_pc);
                    compare_field("halted", want.halted, m_halted);
                    compare_field("status_flags", want.flags, m_status_flags);
                    compare_field("reg_written", want.reg_written, m_reg_written);
                    compare_field("reg_index", want.reg_index, m_reg_index);
                    compare_field("reg_value", want.reg_value, m_reg_value);
                    compare_field("mem_written", want.mem_written, m_mem_written);
                    compare_field("mem_address", want.mem_address, m_mem_address);
                    compare_field("mem_value", want.mem_value, m_mem_value);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
